@@ hw/rtl/sphere_raymarch_pixel_shader_assert.svh @@
// assertion macros shared by the checker of the raymarch shader
`ifndef SPHERE_RAYMARCH_PIXEL_SHADER_ASSERT_SVH
`define SPHERE_RAYMARCH_PIXEL_SHADER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SPHR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sphere raymarch shader check failed");

// consequent checked in the cycle after the antecedent
`define SPHR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sphere raymarch shader check failed");

`endif

@@ hw/rtl/sphr_pkg.sv @@
// types, constants and helpers of the sphere raymarch pixel shader
package sphr_pkg;

	// parameter defaults
	localparam int MAX_STEPS_DEF = 64;
	localparam int FRAC_BITS_DEF = 14;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SINE   = 2'd2;
	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;

	// shading constants, Q2.14
	localparam int AMBIENT   = 1638;
	localparam int K_GREEN   = 3277;
	localparam int K_BLUE    = 1638;
	localparam int ALPHA_ONE = 16384;

	// shared arithmetic units
	localparam int ACC_W   = 64;
	localparam int SQ_RAD_W  = 64;
	localparam int SQ_ROOT_W = 32;
	localparam int SQ_CNT_W  = $clog2(SQ_ROOT_W);
	localparam int DIV_NUM_W = 64;
	localparam int DIV_DEN_W = 32;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

	// multiplier operand pairs
	localparam logic [3:0] MUL_AA   = 4'd0;
	localparam logic [3:0] MUL_BB   = 4'd1;
	localparam logic [3:0] MUL_CC   = 4'd2;
	localparam logic [3:0] MUL_RDXT = 4'd3;
	localparam logic [3:0] MUL_RDYT = 4'd4;
	localparam logic [3:0] MUL_RDZT = 4'd5;
	localparam logic [3:0] MUL_QXX  = 4'd6;
	localparam logic [3:0] MUL_QYY  = 4'd7;
	localparam logic [3:0] MUL_QZZ  = 4'd8;
	localparam logic [3:0] MUL_SVSV = 4'd9;
	localparam logic [3:0] MUL_NXLX = 4'd10;
	localparam logic [3:0] MUL_NYLY = 4'd11;
	localparam logic [3:0] MUL_NZLZ = 4'd12;
	localparam logic [3:0] MUL_D14G = 4'd13;
	localparam logic [3:0] MUL_D14B = 4'd14;

	// accumulator operations
	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD  = 2'd2;

	// square root sources
	localparam logic [1:0] SQ_DIR   = 2'd0;
	localparam logic [1:0] SQ_LEN   = 2'd1;
	localparam logic [1:0] SQ_LIGHT = 2'd2;

	// division jobs: numerator, divisor and destination
	localparam logic [3:0] DV_RDX = 4'd0;
	localparam logic [3:0] DV_RDY = 4'd1;
	localparam logic [3:0] DV_RDZ = 4'd2;
	localparam logic [3:0] DV_NX  = 4'd3;
	localparam logic [3:0] DV_NY  = 4'd4;
	localparam logic [3:0] DV_NZ  = 4'd5;
	localparam logic [3:0] DV_LX  = 4'd6;
	localparam logic [3:0] DV_LY  = 4'd7;
	localparam logic [3:0] DV_LZ  = 4'd8;

	// sample point capture
	localparam logic [1:0] QC_NONE = 2'd0;
	localparam logic [1:0] QC_X    = 2'd1;
	localparam logic [1:0] QC_Y    = 2'd2;
	localparam logic [1:0] QC_Z    = 2'd3;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} in_t;

	typedef struct packed {
		logic [14:0] red;
		logic [14:0] green;
		logic [14:0] blue;
		logic [14:0] alpha;
		logic        hit;
	} out_t;

	typedef struct packed {
		logic       load;
		logic [3:0] mul_sel;
		logic [1:0] acc_op;
		logic       sq_start;
		logic [1:0] sq_sel;
		logic       div_start;
		logic [3:0] div_sel;
		logic [1:0] q_cap;
		logic       t_upd;
		logic       n_zero;
		logic       diff_cap;
		logic       g_cap;
		logic       b_cap;
		logic       out_hit;
		logic       out_miss;
	} cmd_t;

	typedef struct packed {
		logic sq_done;
		logic div_done;
		logic near;
		logic far;
		logic len_zero;
		logic out_free;
	} sts_t;

	// arithmetic shift right that rounds toward zero
	function automatic logic signed [63:0] tz_shr64(input logic signed [63:0] v, input int k);
		logic [63:0] mag;
		logic [63:0] res;
		mag = v[63] ? (64'd0 - v) : v;
		res = mag >> k;
		return v[63] ? $signed(64'd0 - res) : $signed(res);
	endfunction

	// clamp to the 15 bit color range
	function automatic logic [14:0] sat15(input logic signed [63:0] v);
		if (v < 0) begin
			return 15'd0;
		end
		if (v > 64'sd32767) begin
			return 15'h7fff;
		end
		return v[14:0];
	endfunction

endpackage

@@ hw/rtl/sphr_sqrt.sv @@
// iterative floor square root, two radicand bits per cycle
module sphr_sqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [sphr_pkg::SQ_RAD_W-1:0]       rad,
	output logic                                done,
	output logic [sphr_pkg::SQ_ROOT_W-1:0]      root
);

	logic [sphr_pkg::SQ_RAD_W-1:0]  rad_q;
	logic [sphr_pkg::SQ_ROOT_W+1:0] rem_q;
	logic [sphr_pkg::SQ_ROOT_W-1:0] root_q;
	logic [sphr_pkg::SQ_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [sphr_pkg::SQ_ROOT_W+1:0] rem_sh;
	logic [sphr_pkg::SQ_ROOT_W+1:0] trial;
	logic                           fits;

	// one digit of the restoring square root
	assign rem_sh = {rem_q[sphr_pkg::SQ_ROOT_W-1:0], rad_q[sphr_pkg::SQ_RAD_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};
	assign fits   = (rem_sh >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sphr_pkg::SQ_CNT_W'(sphr_pkg::SQ_ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= rad_q << 2;
			if (fits) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[sphr_pkg::SQ_ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[sphr_pkg::SQ_ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ hw/rtl/sphr_div.sv @@
// iterative signed divider, truncating toward zero, one quotient bit per cycle
module sphr_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [sphr_pkg::DIV_NUM_W-1:0] num,
	input  logic [sphr_pkg::DIV_DEN_W-1:0]       den,
	output logic                                 done,
	output logic signed [sphr_pkg::DIV_NUM_W-1:0] quo
);

	logic [sphr_pkg::DIV_NUM_W-1:0] num_q;
	logic [sphr_pkg::DIV_NUM_W-1:0] quo_q;
	logic [sphr_pkg::DIV_DEN_W-1:0] rem_q;
	logic [sphr_pkg::DIV_DEN_W-1:0] den_q;
	logic                           neg_q;
	logic [sphr_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [sphr_pkg::DIV_DEN_W:0]   rem_sh;
	logic                           fits;

	// restoring step on the magnitude
	assign rem_sh = {rem_q, num_q[sphr_pkg::DIV_NUM_W-1]};
	assign fits   = (rem_sh >= {1'b0, den_q});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == sphr_pkg::DIV_CNT_W'(sphr_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[sphr_pkg::DIV_NUM_W-1];
			num_q <= num[sphr_pkg::DIV_NUM_W-1] ? (sphr_pkg::DIV_NUM_W'(0) - num) : num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			if (fits) begin
				rem_q <= sphr_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[sphr_pkg::DIV_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[sphr_pkg::DIV_DEN_W-1:0];
				quo_q <= {quo_q[sphr_pkg::DIV_NUM_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? $signed(sphr_pkg::DIV_NUM_W'(0) - quo_q) : $signed(quo_q);

endmodule

@@ hw/rtl/sphr_dp.sv @@
// datapath: configuration, shared multiplier, accumulator, root and divide units
module sphr_dp #(
	parameter int FRAC_BITS = sphr_pkg::FRAC_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sphr_pkg::cmd_t                     cmd,
	output sphr_pkg::sts_t                     sts,
	input  sphr_pkg::in_t                      in_data,
	input  logic                               cfg_we,
	input  logic [sphr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sphr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output sphr_pkg::out_t                     out_data
);

	localparam int VW = FRAC_BITS + 8;
	localparam longint ONE_L  = longint'(1) << FRAC_BITS;
	localparam longint EPS_L  = (ONE_L + 50) / 100;
	localparam longint TMAX_L = 10 * ONE_L;
	localparam longint EYE_L  = -3 * ONE_L;
	localparam logic signed [VW-1:0] TMAX_Q = VW'(TMAX_L);
	localparam logic signed [VW-1:0] EYE_Q  = VW'(EYE_L);
	localparam int SX_SH  = (FRAC_BITS >= 15) ? FRAC_BITS - 15 : 15 - FRAC_BITS;
	localparam int D14_SH = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 14 - FRAC_BITS;
	localparam int DIR_SH = FRAC_BITS + 16;

	// configuration registers
	logic [12:0]        width_q;
	logic [12:0]        height_q;
	logic signed [15:0] sine_q;

	// per pixel state
	logic signed [14:0]   a_q, b_q, c_q;
	logic signed [VW-1:0] sx_q, t_q;
	logic signed [VW-1:0] rdx_q, rdy_q, rdz_q;
	logic signed [VW-1:0] qx_q, qy_q, qz_q;
	logic signed [VW-1:0] nx_q, ny_q, nz_q;
	logic signed [VW-1:0] lx_q, ly_q, lz_q;
	logic signed [VW-1:0] d14_q, g_q, bl_q;
	logic [sphr_pkg::SQ_ROOT_W-1:0] len_q, ll_q;
	logic signed [2*VW-1:0]  prod_q;
	logic signed [sphr_pkg::ACC_W-1:0] acc_q;
	logic        sq_dst_q;
	logic [3:0]  div_dst_q;
	logic        out_valid_q;
	sphr_pkg::out_t out_q;

	// combinational values
	logic [12:0]          h_eff;
	logic signed [VW-1:0] sine_ext;
	logic signed [VW-1:0] sx_w;
	logic signed [VW-1:0] mul_a, mul_b;
	logic signed [63:0]   prod64;
	logic signed [63:0]   mq;
	logic [sphr_pkg::SQ_RAD_W-1:0] rad;
	logic sq_done;
	logic [sphr_pkg::SQ_ROOT_W-1:0] root;
	logic signed [sphr_pkg::DIV_NUM_W-1:0] div_num;
	logic [sphr_pkg::DIV_DEN_W-1:0] div_den;
	logic div_done;
	logic signed [sphr_pkg::DIV_NUM_W-1:0] quo;
	logic signed [63:0]   d64;
	logic signed [VW-1:0] t_next;
	logic signed [63:0]   dsh, dcl, d14_w;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sphr_pkg::WIDTH_RST;
			height_q <= sphr_pkg::HEIGHT_RST;
			sine_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sphr_pkg::REG_WIDTH:  width_q  <= cfg_data[12:0];
				sphr_pkg::REG_HEIGHT: height_q <= cfg_data[12:0];
				sphr_pkg::REG_SINE:   sine_q   <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// ray setup terms and sphere shift
	assign h_eff    = (height_q == 13'd0) ? 13'd1 : height_q;
	assign sine_ext = VW'(sine_q);
	always_comb begin
		if (FRAC_BITS >= 15) begin
			sx_w = sine_ext <<< SX_SH;
		end else begin
			sx_w = VW'(sphr_pkg::tz_shr64(64'(sine_q), SX_SH));
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			sphr_pkg::MUL_AA:   begin mul_a = VW'(a_q);   mul_b = VW'(a_q);   end
			sphr_pkg::MUL_BB:   begin mul_a = VW'(b_q);   mul_b = VW'(b_q);   end
			sphr_pkg::MUL_CC:   begin mul_a = VW'(c_q);   mul_b = VW'(c_q);   end
			sphr_pkg::MUL_RDXT: begin mul_a = rdx_q;      mul_b = t_q;        end
			sphr_pkg::MUL_RDYT: begin mul_a = rdy_q;      mul_b = t_q;        end
			sphr_pkg::MUL_RDZT: begin mul_a = rdz_q;      mul_b = t_q;        end
			sphr_pkg::MUL_QXX:  begin mul_a = qx_q;       mul_b = qx_q;       end
			sphr_pkg::MUL_QYY:  begin mul_a = qy_q;       mul_b = qy_q;       end
			sphr_pkg::MUL_QZZ:  begin mul_a = qz_q;       mul_b = qz_q;       end
			sphr_pkg::MUL_SVSV: begin mul_a = sine_ext;   mul_b = sine_ext;   end
			sphr_pkg::MUL_NXLX: begin mul_a = nx_q;       mul_b = lx_q;       end
			sphr_pkg::MUL_NYLY: begin mul_a = ny_q;       mul_b = ly_q;       end
			sphr_pkg::MUL_NZLZ: begin mul_a = nz_q;       mul_b = lz_q;       end
			sphr_pkg::MUL_D14G: begin mul_a = d14_q;      mul_b = VW'(sphr_pkg::K_GREEN); end
			sphr_pkg::MUL_D14B: begin mul_a = d14_q;      mul_b = VW'(sphr_pkg::K_BLUE);  end
			default:            begin mul_a = '0;         mul_b = '0;         end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign prod64 = 64'(prod_q);
	assign mq     = sphr_pkg::tz_shr64(prod64, FRAC_BITS);

	// square root unit and its source
	always_comb begin
		case (cmd.sq_sel)
			sphr_pkg::SQ_DIR:   rad = {acc_q[31:0], 32'd0};
			sphr_pkg::SQ_LEN:   rad = acc_q;
			sphr_pkg::SQ_LIGHT: rad = {acc_q[31:0] + 32'h2000_0000, 32'd0};
			default:            rad = '0;
		endcase
	end

	sphr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sq_start),
		.rad    (rad),
		.done   (sq_done),
		.root   (root)
	);

	// divider unit and its operands
	always_comb begin
		div_den = len_q;
		case (cmd.div_sel)
			sphr_pkg::DV_RDX: div_num = 64'(a_q) <<< DIR_SH;
			sphr_pkg::DV_RDY: div_num = 64'(b_q) <<< DIR_SH;
			sphr_pkg::DV_RDZ: div_num = 64'(c_q) <<< DIR_SH;
			sphr_pkg::DV_NX:  div_num = 64'(qx_q) <<< FRAC_BITS;
			sphr_pkg::DV_NY:  div_num = 64'(qy_q) <<< FRAC_BITS;
			sphr_pkg::DV_NZ:  div_num = 64'(qz_q) <<< FRAC_BITS;
			sphr_pkg::DV_LX: begin
				div_num = 64'(sine_q) <<< DIR_SH;
				div_den = ll_q;
			end
			sphr_pkg::DV_LY: begin
				div_num = 64'sd16384 <<< DIR_SH;
				div_den = ll_q;
			end
			sphr_pkg::DV_LZ: begin
				div_num = -(64'sd16384 <<< DIR_SH);
				div_den = ll_q;
			end
			default: div_num = '0;
		endcase
	end

	sphr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	// march distance and next ray length
	assign d64    = $signed({32'd0, len_q}) - ONE_L;
	assign t_next = t_q + VW'(d64);

	// diffuse term moved to Q2.14
	assign dsh = sphr_pkg::tz_shr64(acc_q, FRAC_BITS);
	assign dcl = (dsh < 0) ? 64'sd0 : dsh;
	always_comb begin
		if (FRAC_BITS >= 14) begin
			d14_w = dcl >>> D14_SH;
		end else begin
			d14_w = dcl <<< D14_SH;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q  <= $signed({2'b00, in_data.pixel_x, 1'b0}) - $signed({2'b00, width_q});
			b_q  <= $signed({2'b00, in_data.pixel_y, 1'b0}) - $signed({2'b00, h_eff});
			c_q  <= $signed({1'b0, h_eff, 1'b0});
			sx_q <= sx_w;
			t_q  <= '0;
		end
		if (cmd.t_upd) begin
			t_q <= t_next;
		end
		case (cmd.acc_op)
			sphr_pkg::ACC_LOAD: acc_q <= prod64;
			sphr_pkg::ACC_ADD:  acc_q <= acc_q + prod64;
			default: ;
		endcase
		case (cmd.q_cap)
			sphr_pkg::QC_X: qx_q <= sx_q + VW'(mq);
			sphr_pkg::QC_Y: qy_q <= VW'(mq);
			sphr_pkg::QC_Z: qz_q <= EYE_Q + VW'(mq);
			default: ;
		endcase
		if (cmd.sq_start) begin
			sq_dst_q <= (cmd.sq_sel == sphr_pkg::SQ_LIGHT);
		end
		if (sq_done) begin
			if (sq_dst_q) begin
				ll_q <= root;
			end else begin
				len_q <= root;
			end
		end
		if (cmd.div_start) begin
			div_dst_q <= cmd.div_sel;
		end
		if (div_done) begin
			case (div_dst_q)
				sphr_pkg::DV_RDX: rdx_q <= VW'(quo);
				sphr_pkg::DV_RDY: rdy_q <= VW'(quo);
				sphr_pkg::DV_RDZ: rdz_q <= VW'(quo);
				sphr_pkg::DV_NX:  nx_q  <= VW'(quo);
				sphr_pkg::DV_NY:  ny_q  <= VW'(quo);
				sphr_pkg::DV_NZ:  nz_q  <= VW'(quo);
				sphr_pkg::DV_LX:  lx_q  <= VW'(quo);
				sphr_pkg::DV_LY:  ly_q  <= VW'(quo);
				sphr_pkg::DV_LZ:  lz_q  <= VW'(quo);
				default: ;
			endcase
		end
		if (cmd.n_zero) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= '0;
		end
		if (cmd.diff_cap) begin
			d14_q <= VW'(d14_w);
		end
		if (cmd.g_cap) begin
			g_q <= VW'(prod64 >>> 14);
		end
		if (cmd.b_cap) begin
			bl_q <= VW'(prod64 >>> 14);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_hit || cmd.out_miss) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_hit) begin
			out_q.red   <= sphr_pkg::sat15(64'(d14_q) + sphr_pkg::AMBIENT);
			out_q.green <= sphr_pkg::sat15(64'(g_q) + sphr_pkg::AMBIENT);
			out_q.blue  <= sphr_pkg::sat15(64'(bl_q) + sphr_pkg::AMBIENT);
			out_q.alpha <= sphr_pkg::sat15(64'(d14_q) + sphr_pkg::AMBIENT);
			out_q.hit   <= 1'b1;
		end else if (cmd.out_miss) begin
			out_q.red   <= '0;
			out_q.green <= '0;
			out_q.blue  <= '0;
			out_q.alpha <= 15'(sphr_pkg::ALPHA_ONE);
			out_q.hit   <= 1'b0;
		end
	end

	// status back to the controller
	assign sts.sq_done  = sq_done;
	assign sts.div_done = div_done;
	assign sts.near     = (d64 < EPS_L);
	assign sts.far      = (t_next > TMAX_Q);
	assign sts.len_zero = (len_q == '0);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hw/rtl/sphr_ctrl.sv @@
// controller: sequences setup, march steps and shading on the datapath
module sphr_ctrl #(
	parameter int MAX_STEPS = sphr_pkg::MAX_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output sphr_pkg::cmd_t cmd,
	input  sphr_pkg::sts_t sts
);

	localparam int SW = $clog2(MAX_STEPS + 1);

	localparam logic [5:0] ST_IDLE = 6'd0;
	localparam logic [5:0] ST_D1   = 6'd1;
	localparam logic [5:0] ST_D2   = 6'd2;
	localparam logic [5:0] ST_D3   = 6'd3;
	localparam logic [5:0] ST_D4   = 6'd4;
	localparam logic [5:0] ST_D5   = 6'd5;
	localparam logic [5:0] ST_DVX  = 6'd6;
	localparam logic [5:0] ST_DVY  = 6'd7;
	localparam logic [5:0] ST_DVZ  = 6'd8;
	localparam logic [5:0] ST_M1   = 6'd9;
	localparam logic [5:0] ST_M2   = 6'd10;
	localparam logic [5:0] ST_M3   = 6'd11;
	localparam logic [5:0] ST_M4   = 6'd12;
	localparam logic [5:0] ST_M5   = 6'd13;
	localparam logic [5:0] ST_M6   = 6'd14;
	localparam logic [5:0] ST_M7   = 6'd15;
	localparam logic [5:0] ST_M8   = 6'd16;
	localparam logic [5:0] ST_M9   = 6'd17;
	localparam logic [5:0] ST_EVAL = 6'd18;
	localparam logic [5:0] ST_NX   = 6'd19;
	localparam logic [5:0] ST_NY   = 6'd20;
	localparam logic [5:0] ST_NZ   = 6'd21;
	localparam logic [5:0] ST_L1   = 6'd22;
	localparam logic [5:0] ST_L2   = 6'd23;
	localparam logic [5:0] ST_L3   = 6'd24;
	localparam logic [5:0] ST_LX   = 6'd25;
	localparam logic [5:0] ST_LY   = 6'd26;
	localparam logic [5:0] ST_LZ   = 6'd27;
	localparam logic [5:0] ST_P1   = 6'd28;
	localparam logic [5:0] ST_P2   = 6'd29;
	localparam logic [5:0] ST_P3   = 6'd30;
	localparam logic [5:0] ST_P4   = 6'd31;
	localparam logic [5:0] ST_P5   = 6'd32;
	localparam logic [5:0] ST_P6   = 6'd33;
	localparam logic [5:0] ST_P7   = 6'd34;
	localparam logic [5:0] ST_P8   = 6'd35;
	localparam logic [5:0] ST_FIN  = 6'd36;
	localparam logic [5:0] ST_WSQ  = 6'd37;
	localparam logic [5:0] ST_WDIV = 6'd38;

	logic [5:0]    state_q, state_d;
	logic [5:0]    ret_q, ret_d;
	logic [SW-1:0] step_q;
	logic          hit_q;
	logic          last_step;

	assign last_step = (step_q == SW'(MAX_STEPS - 1));
	assign in_stall  = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_D1;
				end
			end
			// direction length
			ST_D1: begin
				cmd.mul_sel = sphr_pkg::MUL_AA;
				state_d     = ST_D2;
			end
			ST_D2: begin
				cmd.mul_sel = sphr_pkg::MUL_BB;
				cmd.acc_op  = sphr_pkg::ACC_LOAD;
				state_d     = ST_D3;
			end
			ST_D3: begin
				cmd.mul_sel = sphr_pkg::MUL_CC;
				cmd.acc_op  = sphr_pkg::ACC_ADD;
				state_d     = ST_D4;
			end
			ST_D4: begin
				cmd.acc_op = sphr_pkg::ACC_ADD;
				state_d    = ST_D5;
			end
			ST_D5: begin
				cmd.sq_start = 1'b1;
				cmd.sq_sel   = sphr_pkg::SQ_DIR;
				ret_d        = ST_DVX;
				state_d      = ST_WSQ;
			end
			// direction components
			ST_DVX: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_RDX;
				ret_d         = ST_DVY;
				state_d       = ST_WDIV;
			end
			ST_DVY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_RDY;
				ret_d         = ST_DVZ;
				state_d       = ST_WDIV;
			end
			ST_DVZ: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_RDZ;
				ret_d         = ST_M1;
				state_d       = ST_WDIV;
			end
			// sample point
			ST_M1: begin
				cmd.mul_sel = sphr_pkg::MUL_RDXT;
				state_d     = ST_M2;
			end
			ST_M2: begin
				cmd.mul_sel = sphr_pkg::MUL_RDYT;
				cmd.q_cap   = sphr_pkg::QC_X;
				state_d     = ST_M3;
			end
			ST_M3: begin
				cmd.mul_sel = sphr_pkg::MUL_RDZT;
				cmd.q_cap   = sphr_pkg::QC_Y;
				state_d     = ST_M4;
			end
			ST_M4: begin
				cmd.q_cap = sphr_pkg::QC_Z;
				state_d   = ST_M5;
			end
			// distance to the sphere
			ST_M5: begin
				cmd.mul_sel = sphr_pkg::MUL_QXX;
				state_d     = ST_M6;
			end
			ST_M6: begin
				cmd.mul_sel = sphr_pkg::MUL_QYY;
				cmd.acc_op  = sphr_pkg::ACC_LOAD;
				state_d     = ST_M7;
			end
			ST_M7: begin
				cmd.mul_sel = sphr_pkg::MUL_QZZ;
				cmd.acc_op  = sphr_pkg::ACC_ADD;
				state_d     = ST_M8;
			end
			ST_M8: begin
				cmd.acc_op = sphr_pkg::ACC_ADD;
				state_d    = ST_M9;
			end
			ST_M9: begin
				cmd.sq_start = 1'b1;
				cmd.sq_sel   = sphr_pkg::SQ_LEN;
				ret_d        = ST_EVAL;
				state_d      = ST_WSQ;
			end
			// hit test or advance
			ST_EVAL: begin
				if (sts.near) begin
					if (sts.len_zero) begin
						cmd.n_zero = 1'b1;
						state_d    = ST_L1;
					end else begin
						state_d = ST_NX;
					end
				end else begin
					cmd.t_upd = 1'b1;
					if (sts.far || last_step) begin
						state_d = ST_FIN;
					end else begin
						state_d = ST_M1;
					end
				end
			end
			// surface normal
			ST_NX: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_NX;
				ret_d         = ST_NY;
				state_d       = ST_WDIV;
			end
			ST_NY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_NY;
				ret_d         = ST_NZ;
				state_d       = ST_WDIV;
			end
			ST_NZ: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_NZ;
				ret_d         = ST_L1;
				state_d       = ST_WDIV;
			end
			// light direction
			ST_L1: begin
				cmd.mul_sel = sphr_pkg::MUL_SVSV;
				state_d     = ST_L2;
			end
			ST_L2: begin
				cmd.acc_op = sphr_pkg::ACC_LOAD;
				state_d    = ST_L3;
			end
			ST_L3: begin
				cmd.sq_start = 1'b1;
				cmd.sq_sel   = sphr_pkg::SQ_LIGHT;
				ret_d        = ST_LX;
				state_d      = ST_WSQ;
			end
			ST_LX: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_LX;
				ret_d         = ST_LY;
				state_d       = ST_WDIV;
			end
			ST_LY: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_LY;
				ret_d         = ST_LZ;
				state_d       = ST_WDIV;
			end
			ST_LZ: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = sphr_pkg::DV_LZ;
				ret_d         = ST_P1;
				state_d       = ST_WDIV;
			end
			// diffuse dot product and tints
			ST_P1: begin
				cmd.mul_sel = sphr_pkg::MUL_NXLX;
				state_d     = ST_P2;
			end
			ST_P2: begin
				cmd.mul_sel = sphr_pkg::MUL_NYLY;
				cmd.acc_op  = sphr_pkg::ACC_LOAD;
				state_d     = ST_P3;
			end
			ST_P3: begin
				cmd.mul_sel = sphr_pkg::MUL_NZLZ;
				cmd.acc_op  = sphr_pkg::ACC_ADD;
				state_d     = ST_P4;
			end
			ST_P4: begin
				cmd.acc_op = sphr_pkg::ACC_ADD;
				state_d    = ST_P5;
			end
			ST_P5: begin
				cmd.diff_cap = 1'b1;
				state_d      = ST_P6;
			end
			ST_P6: begin
				cmd.mul_sel = sphr_pkg::MUL_D14G;
				state_d     = ST_P7;
			end
			ST_P7: begin
				cmd.mul_sel = sphr_pkg::MUL_D14B;
				cmd.g_cap   = 1'b1;
				state_d     = ST_P8;
			end
			ST_P8: begin
				cmd.b_cap = 1'b1;
				state_d   = ST_FIN;
			end
			// hand the color to the output register
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_hit  = hit_q;
					cmd.out_miss = !hit_q;
					state_d      = ST_IDLE;
				end
			end
			ST_WSQ: begin
				if (sts.sq_done) begin
					state_d = ret_q;
				end
			end
			ST_WDIV: begin
				if (sts.div_done) begin
					state_d = ret_q;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state, return point, step count and hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			step_q  <= '0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			if (cmd.load) begin
				step_q <= '0;
				hit_q  <= 1'b0;
			end else if (state_q == ST_EVAL) begin
				if (sts.near) begin
					hit_q <= 1'b1;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/sphere_raymarch_pixel_shader.sv @@
// top level of the sphere raymarch pixel shader
//
//   port group     dir   handshake           payload
//   in_*           in    in_valid/in_stall    sphr_pkg::in_t  (pixel_x, pixel_y)
//   out_*          out   out_valid/out_stall  sphr_pkg::out_t (red, green, blue, alpha, hit)
//   cfg_*          in    cfg_we               cfg_index, cfg_data
//
// One request at a time: ray setup takes one square root and three divisions,
// each march step one square root, and a hit three more divisions for the normal
// (not when the sample length is zero), one root and three for the light direction.
// Reset clears the controller, the output valid and loads the register defaults.
// A stalled result waits in the output register while the next request is marched.
module sphere_raymarch_pixel_shader #(
	parameter int MAX_STEPS = sphr_pkg::MAX_STEPS_DEF,
	parameter int FRAC_BITS = sphr_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  sphr_pkg::in_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output sphr_pkg::out_t                  out_data,
	input  logic                            cfg_we,
	input  logic [sphr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sphr_pkg::CFG_DATA_W-1:0] cfg_data
);

	sphr_pkg::cmd_t cmd;
	sphr_pkg::sts_t sts;

	// sequencer
	sphr_ctrl #(
		.MAX_STEPS (MAX_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	// arithmetic
	sphr_dp #(
		.FRAC_BITS (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

@@ hw/rtl/sphr_checker.sv @@
// port level checks of the sphere raymarch pixel shader, bound to the top level
`include "sphere_raymarch_pixel_shader_assert.svh"

module sphr_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input sphr_pkg::out_t out_data
);

	// a taken request keeps the block busy for at least the next cycle
	`SPHR_ASSERT_NEXT(busy_after_req, clk, arst_n, in_valid && !in_stall, in_stall)

	// a stalled result holds
	`SPHR_ASSERT_NEXT(out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))

	// a miss is opaque black
	`SPHR_ASSERT_SAME(miss_black, clk, arst_n, out_valid && !out_data.hit, out_data.red == 15'd0 && out_data.green == 15'd0 && out_data.blue == 15'd0 && out_data.alpha == 15'(sphr_pkg::ALPHA_ONE))

	// a hit has alpha equal to red, tints ordered and at least ambient
	`SPHR_ASSERT_SAME(hit_tint, clk, arst_n, out_valid && out_data.hit, out_data.alpha == out_data.red && out_data.blue <= out_data.green && out_data.green <= out_data.red && out_data.blue >= 15'(sphr_pkg::AMBIENT))

endmodule

bind sphere_raymarch_pixel_shader sphr_checker u_sphr_checker (.*);

@@ dv/testbench.sv @@
// self-checking testbench of the sphere raymarch pixel shader
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  FB       = sphr_pkg::FRAC_BITS_DEF;
	localparam int  STEPS    = sphr_pkg::MAX_STEPS_DEF;
	localparam longint ONE_Q = longint'(1) << FB;
	localparam longint EPS_Q = (ONE_Q + 50) / 100;
	localparam longint FAR_Q = 10 * ONE_Q;
	localparam longint SCALE = longint'(1) << (FB + 16);
	localparam logic [sphr_pkg::CFG_IDX_W-1:0] REG_BAD = 2'd3;
	localparam longint CYCLE_LIMIT = 40000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sphr_pkg::in_t  in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sphr_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [sphr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sphr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the registers
	logic [12:0] frame_w = 13'd640;
	logic [12:0] frame_h = 13'd480;
	logic [15:0] sine_q  = 16'd0;

	sphr_pkg::in_t  pending_px[$];
	sphr_pkg::out_t color_expected[$];
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   failures = 0;
	int   sent_cnt = 0;
	int   hit_cnt = 0;
	int   color_cnt = 0;
	longint cycle_cnt = 0;

	sphere_raymarch_pixel_shader dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// floor square root
	function automatic longint root64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] probe;
		res = 0;
		probe = 64'd1 << 62;
		while (probe > v) probe = probe >> 2;
		while (probe != 0) begin
			if (v >= res + probe) begin
				v = v - (res + probe);
				res = (res >> 1) + probe;
			end else begin
				res = res >> 1;
			end
			probe = probe >> 2;
		end
		return longint'(res);
	endfunction

	// shift right rounding toward zero
	function automatic longint shr_tz(input longint v, input int k);
		if (v < 0) return -((-v) >>> k);
		return v >>> k;
	endfunction

	function automatic logic [14:0] clamp15(input longint v);
		if (v < 0) return 15'd0;
		if (v > 32767) return 15'h7fff;
		return v[14:0];
	endfunction

	// color of one pixel under the current register values
	function automatic sphr_pkg::out_t shade_pixel(input sphr_pkg::in_t px);
		longint w, h, sv, a, b, c, dl, rdx, rdy, rdz, sx, t;
		longint qx, qy, qz, len, dstep, nx, ny, nz, ll, lx, ly, lz, diff;
		sphr_pkg::out_t res;
		bit   done;
		w  = frame_w;
		h  = (frame_h == 0) ? 1 : frame_h;
		sv = longint'($signed(sine_q));
		a  = 2 * longint'(px.pixel_x) - w;
		b  = 2 * longint'(px.pixel_y) - h;
		c  = 2 * h;
		dl = root64(64'(a * a + b * b + c * c) << 32);
		rdx = (a * SCALE) / dl;
		rdy = (b * SCALE) / dl;
		rdz = (c * SCALE) / dl;
		sx = shr_tz(sv, 15 - FB);
		t = 0;
		res = '{red: 15'd0, green: 15'd0, blue: 15'd0,
			alpha: 15'(sphr_pkg::ALPHA_ONE), hit: 1'b0};
		done = 0;
		for (int i = 0; i < STEPS && !done; i++) begin
			qx = sx + shr_tz(rdx * t, FB);
			qy = shr_tz(rdy * t, FB);
			qz = -3 * ONE_Q + shr_tz(rdz * t, FB);
			len = root64(64'(qx * qx) + 64'(qy * qy) + 64'(qz * qz));
			dstep = len - ONE_Q;
			if (dstep < EPS_Q) begin
				nx = 0; ny = 0; nz = 0;
				if (len != 0) begin
					nx = (qx * ONE_Q) / len;
					ny = (qy * ONE_Q) / len;
					nz = (qz * ONE_Q) / len;
				end
				ll = root64(64'(sv * sv + 2 * (longint'(1) << 28)) << 32);
				lx = (sv * SCALE) / ll;
				ly = (16384 * SCALE) / ll;
				lz = (-16384 * SCALE) / ll;
				diff = shr_tz(nx * lx + ny * ly + nz * lz, FB);
				if (diff < 0) diff = 0;
				diff = diff >>> (FB - 14);
				res.red   = clamp15(diff + sphr_pkg::AMBIENT);
				res.green = clamp15(((diff * sphr_pkg::K_GREEN) >>> 14) + sphr_pkg::AMBIENT);
				res.blue  = clamp15(((diff * sphr_pkg::K_BLUE) >>> 14) + sphr_pkg::AMBIENT);
				res.alpha = res.red;
				res.hit   = 1'b1;
				done = 1;
			end else begin
				t = t + dstep;
				if (t > FAR_Q) done = 1;
			end
		end
		return res;
	endfunction

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				color_expected.push_back(shade_pixel(in_data));
				sent_cnt++;
			end
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (pending_px.size() > 0 && $urandom_range(99) >= idle_pct) begin
				in_valid <= 1'b1;
				in_data  <= pending_px.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (out_valid && !out_stall) begin
				if (color_expected.size() == 0) begin
					$error("unexpected result %p", out_data);
					failures++;
				end else begin
					sphr_pkg::out_t exp_c;
					exp_c = color_expected.pop_front();
					color_cnt++;
					if (exp_c.hit) hit_cnt++;
					if (out_data.red !== exp_c.red) begin
						$error("red expected %0d actual %0d", exp_c.red, out_data.red);
						failures++;
					end
					if (out_data.green !== exp_c.green) begin
						$error("green expected %0d actual %0d", exp_c.green, out_data.green);
						failures++;
					end
					if (out_data.blue !== exp_c.blue) begin
						$error("blue expected %0d actual %0d", exp_c.blue, out_data.blue);
						failures++;
					end
					if (out_data.alpha !== exp_c.alpha) begin
						$error("alpha expected %0d actual %0d", exp_c.alpha, out_data.alpha);
						failures++;
					end
					if (out_data.hit !== exp_c.hit) begin
						$error("hit expected %0d actual %0d", exp_c.hit, out_data.hit);
						failures++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [sphr_pkg::CFG_IDX_W-1:0] idx,
		input logic [sphr_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sphr_pkg::REG_WIDTH:  frame_w = val[12:0];
			sphr_pkg::REG_HEIGHT: frame_h = val[12:0];
			sphr_pkg::REG_SINE:   sine_q  = val;
			default: ;
		endcase
	endtask

	// sampled away from the rising edge so that driver updates have settled
	task automatic wait_idle();
		@(negedge clk);
		while (pending_px.size() > 0 || in_valid || color_expected.size() > 0)
			@(negedge clk);
		repeat (50) @(posedge clk);
	endtask

	function automatic sphr_pkg::in_t make_px(input int x, input int y);
		sphr_pkg::in_t p;
		p.pixel_x = 12'(x);
		p.pixel_y = 12'(y);
		return p;
	endfunction

	// random pixel, mostly inside the frame so that the sphere is reached
	function automatic sphr_pkg::in_t random_px();
		int wmax, hmax;
		if ($urandom_range(99) < 20)
			return make_px($urandom_range(4095), $urandom_range(4095));
		wmax = (frame_w > 4096) ? 4095 : ((frame_w == 0) ? 0 : frame_w - 1);
		hmax = (frame_h > 4096) ? 4095 : ((frame_h == 0) ? 0 : frame_h - 1);
		if ($urandom_range(99) < 60)
			return make_px(frame_w / 2 + $urandom_range(frame_w / 3) - frame_w / 6,
				frame_h / 2 + $urandom_range(frame_h / 3) - frame_h / 6);
		return make_px($urandom_range(wmax), $urandom_range(hmax));
	endfunction

	initial begin
		int widths[8]  = '{640, 1, 4096, 0, 200, 33, 1024, 7};
		int heights[8] = '{480, 1, 4096, 0, 150, 3000, 17, 5};
		int sines[8]   = '{0, 16384, -16384, 32767, -32768, 8192, -5000, 1};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed pixels at reset settings
		pending_px.push_back(make_px(0, 0));
		pending_px.push_back(make_px(4095, 4095));
		pending_px.push_back(make_px(4095, 0));
		pending_px.push_back(make_px(0, 4095));
		pending_px.push_back(make_px(320, 240));
		pending_px.push_back(make_px(321, 240));
		pending_px.push_back(make_px(320, 100));
		pending_px.push_back(make_px(420, 300));
		pending_px.push_back(make_px(200, 240));
		pending_px.push_back(make_px(639, 479));
		pending_px.push_back(make_px(2730, 1365));
		pending_px.push_back(make_px(1365, 2730));
		wait_idle();
		write_reg(REG_BAD, 16'h0001);
		write_reg(sphr_pkg::REG_SINE, 16'h4000);
		pending_px.push_back(make_px(320, 240));
		pending_px.push_back(make_px(360, 220));
		pending_px.push_back(make_px(280, 260));
		wait_idle();

		// random phases over settings, idle and stall patterns
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 71; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 71; end
				default: begin idle_pct = 8; stall_pct = 8; end
			endcase
			write_reg(sphr_pkg::REG_WIDTH, 16'(widths[ph]));
			write_reg(sphr_pkg::REG_HEIGHT, 16'(heights[ph]));
			write_reg(sphr_pkg::REG_SINE, 16'(sines[ph]));
			for (int n = 0; n < 44; n++) pending_px.push_back(random_px());
			wait_idle();
		end

		$display("testbench: %0d pixels shaded, %0d hits, over 8 register settings",
			color_cnt, hit_cnt);
		$display("testbench: idle and stall patterns of 0, 8 and 71 percent on both sides");
		if (failures == 0 && color_expected.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

@@ sphere_raymarch_pixel_shader.f @@
+incdir+hw/rtl
hw/rtl/sphr_pkg.sv
hw/rtl/sphr_sqrt.sv
hw/rtl/sphr_div.sv
hw/rtl/sphr_dp.sv
hw/rtl/sphr_ctrl.sv
hw/rtl/sphere_raymarch_pixel_shader.sv
hw/rtl/sphr_checker.sv
dv/testbench.sv
